>>> hw/rtl/lsq_pkg.sv
package lsq_pkg;

    // lane storage geometry
    localparam int LANE_COUNT   = 64;
    localparam int LANE_W       = (LANE_COUNT > 1) ? $clog2(LANE_COUNT) : 1;
    localparam int HALF_COUNT   = LANE_COUNT / 2;

    // field widths
    localparam int LANE_FIELD_W = 6;
    localparam int OCC_W        = 8;
    localparam int POL_W        = 8;
    localparam int IN_DATA_W    = 24;
    localparam int OUT_DATA_W   = 8;

    // request kinds carried on tuser
    localparam logic KIND_UPDATE = 1'b0;
    localparam logic KIND_SELECT = 1'b1;

    // policy codes
    localparam logic [POL_W-1:0] POL_PASS       = 8'd0;
    localparam logic [POL_W-1:0] POL_LEAST_ALL  = 8'd1;
    localparam logic [POL_W-1:0] POL_LEAST_LO   = 8'd2;
    localparam logic [POL_W-1:0] POL_LEAST_HI   = 8'd3;
    localparam logic [POL_W-1:0] POL_MOST_LO    = 8'd4;
    localparam logic [POL_W-1:0] POL_MOST_HI    = 8'd5;
    localparam logic [POL_W-1:0] POL_MOST_ALL   = 8'd6;

    localparam logic [OCC_W-1:0] LIMIT_RESET    = 8'd255;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_POST
    } lsq_state_t;

    // control from the sequencer to the compare unit
    typedef struct packed {
        logic init;
        logic step;
        logic least;
    } lsq_cmp_ctl_t;

    // decoded policy: scan range and direction
    typedef struct packed {
        logic              scan;
        logic              least;
        logic [LANE_W-1:0] first;
        logic [LANE_W-1:0] last;
    } lsq_pol_t;

    function automatic lsq_pol_t pol_decode(input logic [POL_W-1:0] pol);
        lsq_pol_t d;
        d.scan  = 1'b1;
        d.least = 1'b1;
        d.first = '0;
        d.last  = LANE_W'(LANE_COUNT - 1);
        case (pol)
            POL_LEAST_ALL:
            begin
                d.least = 1'b1;
            end
            POL_LEAST_LO:
            begin
                d.last  = LANE_W'(HALF_COUNT - 1);
            end
            POL_LEAST_HI:
            begin
                d.first = LANE_W'(HALF_COUNT);
            end
            POL_MOST_LO:
            begin
                d.least = 1'b0;
                d.last  = LANE_W'(HALF_COUNT - 1);
            end
            POL_MOST_HI:
            begin
                d.least = 1'b0;
                d.first = LANE_W'(HALF_COUNT);
            end
            POL_MOST_ALL:
            begin
                d.least = 1'b0;
            end
            default:
            begin
                d.scan  = 1'b0;
            end
        endcase
        return d;
    endfunction

endpackage

>>> hw/rtl/lane_select_by_queue_load.sv
// update request: accepted while idle; ready is still high on the next cycle
// select request with pass-through or unknown policy: the requesting lane is registered as the result
// select request with a scan over N lanes: chosen lane registered when the scan ends
// (one stored count read per cycle through the single RAM read port); not ready meanwhile
// reset clears all lane counts to zero through per-lane valid flops, queue_limit to 255
module lane_select_by_queue_load (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration: queue_limit
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lsq_pkg::OCC_W-1:0]        cfg_data,
    // input requests
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [lsq_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // lane[5:0], occupancy[13:6], policy[21:14]
    input  logic                             s_axis_tuser,  // kind[0]
    // chosen lanes
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [lsq_pkg::OUT_DATA_W-1:0]   m_axis_tdata   // chosen_lane[5:0]
);

    localparam int LW = lsq_pkg::LANE_W;
    localparam int FW = lsq_pkg::LANE_FIELD_W;

    lsq_pkg::lsq_state_t          state_reg, state_next;
    logic [lsq_pkg::OCC_W-1:0]    limit_reg;
    logic [lsq_pkg::LANE_COUNT-1:0] valid_reg;
    logic [LW-1:0]                addr_reg, last_reg;
    logic                         issue_reg, pend_reg, pend_vld_reg, least_reg;
    logic [LW-1:0]                pend_idx_reg;
    logic                         out_valid_reg;
    logic [FW-1:0]                out_lane_reg;

    logic [FW-1:0]                in_lane;
    logic [lsq_pkg::OCC_W-1:0]    in_occ;
    logic [lsq_pkg::POL_W-1:0]    in_pol;
    logic                         in_acc, sel_req, upd_req, upd_ok;
    lsq_pkg::lsq_pol_t            dec;
    lsq_pkg::lsq_cmp_ctl_t        cmp_ctl;
    logic [lsq_pkg::OCC_W-1:0]    ram_rdata, count;
    logic [FW-1:0]                best;
    logic                         hit, scan_end, out_load;

    // request decode
    assign in_lane = s_axis_tdata[FW-1:0];
    assign in_occ  = s_axis_tdata[FW+lsq_pkg::OCC_W-1:FW];
    assign in_pol  = s_axis_tdata[FW+lsq_pkg::OCC_W+lsq_pkg::POL_W-1:FW+lsq_pkg::OCC_W];
    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign sel_req = in_acc && (s_axis_tuser == lsq_pkg::KIND_SELECT);
    assign upd_req = in_acc && (s_axis_tuser == lsq_pkg::KIND_UPDATE);
    assign upd_ok  = upd_req && (int'(in_lane) < lsq_pkg::LANE_COUNT);
    assign dec     = lsq_pkg::pol_decode(in_pol);

    assign scan_end = hit || (!issue_reg && !pend_reg);
    assign cfg_ready = 1'b1;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lsq_pkg::ST_IDLE:
            begin
                if (sel_req)
                begin
                    state_next = dec.scan ? lsq_pkg::ST_SCAN : lsq_pkg::ST_POST;
                end
            end
            lsq_pkg::ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = lsq_pkg::ST_POST;
                end
            end
            lsq_pkg::ST_POST:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    state_next = lsq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lsq_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        out_load      = 1'b0;
        cmp_ctl.init  = sel_req;
        cmp_ctl.step  = 1'b0;
        cmp_ctl.least = sel_req ? dec.least : least_reg;
        case (state_reg)
            lsq_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
            end
            lsq_pkg::ST_SCAN:
            begin
                cmp_ctl.step = pend_reg;
            end
            lsq_pkg::ST_POST:
            begin
                out_load = !out_valid_reg || m_axis_tready;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // state, limit register and lane valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lsq_pkg::ST_IDLE;
            limit_reg <= lsq_pkg::LIMIT_RESET;
            valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
            end
            if (upd_ok)
            begin
                valid_reg[in_lane[LW-1:0]] <= 1'b1;
            end
        end
    end

    // read address sweep and read pipeline tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            if (sel_req)
            begin
                issue_reg <= dec.scan;
            end
            else if (state_reg == lsq_pkg::ST_SCAN && issue_reg)
            begin
                issue_reg <= !(addr_reg == last_reg) && !hit;
            end
            else
            begin
                issue_reg <= 1'b0;
            end
            pend_reg <= (state_reg == lsq_pkg::ST_SCAN) && issue_reg && !hit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sel_req)
        begin
            addr_reg  <= dec.first;
            last_reg  <= dec.last;
            least_reg <= dec.least;
        end
        else if (state_reg == lsq_pkg::ST_SCAN && issue_reg)
        begin
            addr_reg <= addr_reg + 1'b1;
        end
        pend_idx_reg <= addr_reg;
        pend_vld_reg <= valid_reg[addr_reg];
    end

    // occupancy storage
    lsq_ram #(
        .WIDTH (lsq_pkg::OCC_W),
        .DEPTH (lsq_pkg::LANE_COUNT)
    ) u_ram (
        .clk   (clk),
        .we    (upd_ok),
        .waddr (in_lane[LW-1:0]),
        .wdata (in_occ),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    // a lane never written since reset counts as empty
    assign count = pend_vld_reg ? ram_rdata : '0;

    lsq_cmp u_cmp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (cmp_ctl),
        .init_bound (dec.least ? limit_reg : '0),
        .init_best  (in_lane),
        .count      (count),
        .idx        (FW'(pend_idx_reg)),
        .best       (best),
        .hit        (hit)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_lane_reg <= best;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(lsq_pkg::OUT_DATA_W-FW){1'b0}}, out_lane_reg};

endmodule

>>> hw/rtl/lsq_ram.sv
module lsq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/lsq_cmp.sv
module lsq_cmp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  lsq_pkg::lsq_cmp_ctl_t             ctl,
    input  logic [lsq_pkg::OCC_W-1:0]         init_bound,
    input  logic [lsq_pkg::LANE_FIELD_W-1:0]  init_best,
    input  logic [lsq_pkg::OCC_W-1:0]         count,
    input  logic [lsq_pkg::LANE_FIELD_W-1:0]  idx,
    output logic [lsq_pkg::LANE_FIELD_W-1:0]  best,
    output logic                              hit
);

    logic [lsq_pkg::OCC_W-1:0]        bound_reg, bound_next;
    logic [lsq_pkg::LANE_FIELD_W-1:0] best_reg, best_next;
    logic                             hit_reg, hit_next;
    logic [lsq_pkg::OCC_W-1:0]        op_a, op_b;
    logic                             better;

    // one shared less-than: count < bound for least, bound < count for most
    always_comb
    begin
        op_a   = ctl.least ? count : bound_reg;
        op_b   = ctl.least ? bound_reg : count;
        better = (op_a < op_b);
    end

    // running best lane and bound
    always_comb
    begin
        bound_next = bound_reg;
        best_next  = best_reg;
        hit_next   = hit_reg;
        if (ctl.init)
        begin
            bound_next = init_bound;
            best_next  = init_best;
            hit_next   = 1'b0;
        end
        else if (ctl.step && !hit_reg)
        begin
            if (ctl.least && count == '0)
            begin
                best_next = idx;
                hit_next  = 1'b1;
            end
            else if (better)
            begin
                bound_next = count;
                best_next  = idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bound_reg <= bound_next;
        best_reg  <= best_next;
    end

    assign best = best_reg;
    assign hit  = hit_reg;

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

    // quiet cycles added after the last chosen lane before a queue_limit write
    localparam int SCAN_SETTLE = lsq_pkg::LANE_COUNT + 8;

    // first policy code past the defined ones
    localparam logic [lsq_pkg::POL_W-1:0] POL_MOST_POL_OR_UNKNOWN_FIRST =
        lsq_pkg::POL_MOST_ALL + 8'd1;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [lsq_pkg::OCC_W-1:0]          cfg_data = '0;
    logic                               s_axis_tvalid = 1'b0;
    logic                               s_axis_tready;
    logic [lsq_pkg::IN_DATA_W-1:0]      s_axis_tdata = '0;  // lane[5:0], occupancy[13:6], policy[21:14]
    logic                               s_axis_tuser = 1'b0;  // kind[0]
    logic                               m_axis_tvalid;
    logic                               m_axis_tready = 1'b0;
    logic [lsq_pkg::OUT_DATA_W-1:0]     m_axis_tdata;  // chosen_lane[5:0]

    // shadow of the block state
    logic [lsq_pkg::OCC_W-1:0]          lane_counts [lsq_pkg::LANE_COUNT];
    logic [lsq_pkg::OCC_W-1:0]          limit_shadow = lsq_pkg::LIMIT_RESET;

    // chosen lanes still owed by the block, oldest first
    logic [lsq_pkg::LANE_FIELD_W-1:0]   pending_choices [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int error_count = 0;
    int updates_sent = 0;
    int selects_sent = 0;
    int choices_checked = 0;
    int limit_writes = 0;

    lane_select_by_queue_load dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // hard stop
    initial
    begin
        #10_000_000;
        $display("testbench failed");
        $finish;
    end

    // receiver backpressure
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // expected lane for a select request against the current shadow state
    function automatic logic [lsq_pkg::LANE_FIELD_W-1:0] predict_lane(
        input logic [lsq_pkg::LANE_FIELD_W-1:0] requester,
        input logic [lsq_pkg::POL_W-1:0]        policy
    );
        int                                lo;
        int                                hi;
        int                                i;
        bit                                least;
        logic [lsq_pkg::OCC_W-1:0]         bound;
        logic [lsq_pkg::LANE_FIELD_W-1:0]  best;
        lo    = 0;
        hi    = lsq_pkg::LANE_COUNT;
        least = 1'b1;
        case (policy)
            lsq_pkg::POL_LEAST_ALL:
            begin
                least = 1'b1;
            end
            lsq_pkg::POL_LEAST_LO:
            begin
                hi = lsq_pkg::HALF_COUNT;
            end
            lsq_pkg::POL_LEAST_HI:
            begin
                lo = lsq_pkg::HALF_COUNT;
            end
            lsq_pkg::POL_MOST_LO:
            begin
                least = 1'b0;
                hi    = lsq_pkg::HALF_COUNT;
            end
            lsq_pkg::POL_MOST_HI:
            begin
                least = 1'b0;
                lo    = lsq_pkg::HALF_COUNT;
            end
            lsq_pkg::POL_MOST_ALL:
            begin
                least = 1'b0;
            end
            default:
            begin
                return requester;
            end
        endcase
        best = requester;
        if (least)
        begin
            // first empty lane wins at once, else strictly smallest below the limit
            bound = limit_shadow;
            for (i = lo; i < hi; i++)
            begin
                if (lane_counts[i] == '0)
                    return lsq_pkg::LANE_FIELD_W'(i);
                if (lane_counts[i] < bound)
                begin
                    bound = lane_counts[i];
                    best  = lsq_pkg::LANE_FIELD_W'(i);
                end
            end
        end
        else
        begin
            // strictly largest nonzero count
            bound = '0;
            for (i = lo; i < hi; i++)
            begin
                if (lane_counts[i] > bound)
                begin
                    bound = lane_counts[i];
                    best  = lsq_pkg::LANE_FIELD_W'(i);
                end
            end
        end
        return best;
    endfunction

    // compare each chosen lane with the oldest pending one
    always @(posedge clk)
    begin
        logic [lsq_pkg::LANE_FIELD_W-1:0] want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_choices.size() == 0)
            begin
                $display("%0t: chosen_lane %0d with no select request pending",
                         $time, m_axis_tdata[lsq_pkg::LANE_FIELD_W-1:0]);
                error_count++;
            end
            else
            begin
                want = pending_choices.pop_front();
                choices_checked++;
                if (m_axis_tdata[lsq_pkg::LANE_FIELD_W-1:0] !== want)
                begin
                    $display("%0t: chosen_lane mismatch, expected %0d, actual %0d",
                             $time, want, m_axis_tdata[lsq_pkg::LANE_FIELD_W-1:0]);
                    error_count++;
                end
            end
        end
    end

    // one request on the input stream, with a random gap ahead of it
    task automatic send_request(
        input logic                             kind,
        input logic [lsq_pkg::LANE_FIELD_W-1:0] lane,
        input logic [lsq_pkg::OCC_W-1:0]        occupancy,
        input logic [lsq_pkg::POL_W-1:0]        policy
    );
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {2'b00, policy, occupancy, lane};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        // request taken: update the shadow or queue the expected lane
        if (kind == lsq_pkg::KIND_UPDATE)
        begin
            if (int'(lane) < lsq_pkg::LANE_COUNT)
                lane_counts[lane] = occupancy;
            updates_sent++;
        end
        else
        begin
            pending_choices.insert(pending_choices.size(), predict_lane(lane, policy));
            selects_sent++;
        end
    endtask

    // unused fields carry random bits
    task automatic send_update(input int lane, input int occupancy);
        send_request(lsq_pkg::KIND_UPDATE, lsq_pkg::LANE_FIELD_W'(lane),
                     lsq_pkg::OCC_W'(occupancy), lsq_pkg::POL_W'($urandom_range(255)));
    endtask

    task automatic send_select(input int requester, input logic [lsq_pkg::POL_W-1:0] policy);
        send_request(lsq_pkg::KIND_SELECT, lsq_pkg::LANE_FIELD_W'(requester),
                     lsq_pkg::OCC_W'($urandom_range(255)), policy);
    endtask

    // stop sending and let every pending choice and any scan finish
    task automatic drain_block();
        s_axis_tvalid <= 1'b0;
        while (pending_choices.size() != 0)
            @(posedge clk);
        repeat (SCAN_SETTLE) @(posedge clk);
    endtask

    task automatic write_queue_limit(input logic [lsq_pkg::OCC_W-1:0] value);
        drain_block();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid    <= 1'b0;
        limit_shadow = value;
        limit_writes++;
    endtask

    // all counts zero after reset, limit at its reset value
    task automatic test_reset_state();
        send_select(63, lsq_pkg::POL_LEAST_ALL);
        send_select(0, lsq_pkg::POL_LEAST_HI);
        send_select(21, lsq_pkg::POL_LEAST_LO);
        send_select(5, lsq_pkg::POL_MOST_LO);
        send_select(42, lsq_pkg::POL_MOST_HI);
        send_select(63, lsq_pkg::POL_MOST_ALL);
        send_select(63, lsq_pkg::POL_PASS);
    endtask

    // field extremes, ties, unknown policy codes
    task automatic test_directed_cases();
        send_update(63, 255);
        send_update(0, 1);
        send_select(3, lsq_pkg::POL_MOST_ALL);
        send_select(3, lsq_pkg::POL_MOST_LO);
        send_select(3, lsq_pkg::POL_MOST_HI);
        send_select(9, lsq_pkg::POL_LEAST_LO);
        send_update(32, 128);
        send_update(40, 255);
        send_select(0, lsq_pkg::POL_MOST_HI);
        send_select(17, POL_MOST_POL_OR_UNKNOWN_FIRST);
        send_select(17, lsq_pkg::POL_W'(255));
        send_select(60, lsq_pkg::POL_W'(128));
        send_update(0, 0);
        send_select(11, lsq_pkg::POL_LEAST_ALL);
    endtask

    // rounds of full fills followed by mixed traffic, one limit setting per round
    task automatic test_random_traffic(input int send_pct, input int recv_pct);
        int round;
        int step;
        int max_occ;
        int pick;
        logic [lsq_pkg::OCC_W-1:0] limit_value;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (round = 0; round < 4; round++)
        begin
            case ($urandom_range(3))
                0:       max_occ = 1;
                1:       max_occ = 3;
                2:       max_occ = 15;
                default: max_occ = 255;
            endcase
            // limit extremes first, then values near the counts or anywhere
            if (round == 0)
                limit_value = '0;
            else if (round == 1)
                limit_value = lsq_pkg::LIMIT_RESET;
            else if ($urandom_range(1) == 0)
                limit_value = lsq_pkg::OCC_W'($urandom_range((max_occ < 255) ?
                                                             max_occ + 1 : 255));
            else
                limit_value = lsq_pkg::OCC_W'($urandom_range(255));
            write_queue_limit(limit_value);

            // every lane nonzero so scans run to the end
            for (step = 0; step < lsq_pkg::LANE_COUNT; step++)
                send_update(step, $urandom_range(1, max_occ));

            // selects, count changes and some raw noise
            for (step = 0; step < 70; step++)
            begin
                pick = $urandom_range(99);
                if (pick < 55)
                begin
                    if ($urandom_range(99) < 80)
                        send_select($urandom_range(63),
                                    lsq_pkg::POL_W'($urandom_range(lsq_pkg::POL_LEAST_ALL,
                                                                   lsq_pkg::POL_MOST_ALL)));
                    else
                        send_select($urandom_range(63), lsq_pkg::POL_W'($urandom_range(255)));
                end
                else if (pick < 90)
                begin
                    if ($urandom_range(9) == 0)
                        send_update($urandom_range(63), 0);
                    else
                        send_update($urandom_range(63), $urandom_range(1, max_occ));
                end
                else
                begin
                    send_request(1'($urandom_range(1)),
                                 lsq_pkg::LANE_FIELD_W'($urandom_range(63)),
                                 lsq_pkg::OCC_W'($urandom_range(255)),
                                 lsq_pkg::POL_W'($urandom_range(255)));
                end
            end
        end
    endtask

    initial
    begin
        int i;
        for (i = 0; i < lsq_pkg::LANE_COUNT; i++)
            lane_counts[i] = '0;

        // reset
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_directed_cases();
        test_random_traffic(14, 86);
        test_random_traffic(86, 14);
        test_random_traffic(0, 0);

        // let the last choices come back
        drain_block();

        $display("covered %0d occupancy updates and %0d lane choices (%0d checked)",
                 updates_sent, selects_sent, choices_checked);
        $display("over %0d queue_limit settings including 0 and 255, all seven policies",
                 limit_writes);
        if (error_count == 0)
        begin
            $display("testbench passed");
        end
        else
        begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/lsq_pkg.sv
hw/rtl/lsq_ram.sv
hw/rtl/lsq_cmp.sv
hw/rtl/lane_select_by_queue_load.sv
sim/testbench.sv
